// ===== rtl/core/adpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants for the 4-bit predictive ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 2;

   localparam int SAMPLE_W       = 16;
   localparam int BYTE_W         = 8;
   localparam int NIBBLE_W       = 4;
   localparam int SCALE_W        = 17;
   localparam int COEF_FRAC_BITS = 12;
   localparam int OPERAND_W      = 18;
   localparam int PROD_W         = 2 * OPERAND_W;
   localparam int ACC_W          = PROD_W - COEF_FRAC_BITS;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CHAN_CNT_W  = 2;

   localparam int SAMPLE_MAX     = 32767;
   localparam int SAMPLE_MIN     = -32768;
   localparam int MIN_FRAME_SIZE = 3;
   localparam int STEREO_COUNT   = 2;

   localparam logic [CHAN_CNT_W-1:0] CHAN_COUNT_RESET = 2'd1;
   localparam logic [BYTE_W-1:0]     FRAME_SIZE_RESET = 8'd18;
   localparam logic [SCALE_W-1:0]    STEP_SCALE_RESET = 17'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_ONE        = 3'd0,
      CSR_COEF_TWO        = 3'd1,
      CSR_CHANNEL_COUNT   = 3'd2,
      CSR_FRAME_SIZE      = 3'd3,
      CSR_PREV_ONE_LEFT   = 3'd4,
      CSR_PREV_TWO_LEFT   = 3'd5,
      CSR_PREV_ONE_RIGHT  = 3'd6,
      CSR_PREV_TWO_RIGHT  = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ONE,
      ST_MUL_TWO,
      ST_MUL_STEP,
      ST_SUM,
      ST_STORE
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_SHR,
      ACC_ADD_SHR,
      ACC_ADD_FULL
   } acc_sel_type;

   typedef struct packed {
      logic        mul_en;
      acc_sel_type acc_sel;
   } mac_ctrl_type;

endpackage

// ===== rtl/core/adpcm_mac.sv =====
// ----------------------------------------------------------------------------
// adpcm_mac
// Shared signed multiplier with registered product and accumulator.
// ----------------------------------------------------------------------------
module adpcm_mac (
   input  logic                                      clock,
   input  adpcm_pkg::mac_ctrl_type                   ctrl,
   input  logic signed [adpcm_pkg::OPERAND_W-1:0]    op_a,
   input  logic signed [adpcm_pkg::OPERAND_W-1:0]    op_b,
   output logic signed [adpcm_pkg::ACC_W-1:0]        acc
);

   localparam int PROD_W = adpcm_pkg::PROD_W;
   localparam int ACC_W  = adpcm_pkg::ACC_W;
   localparam int FRAC   = adpcm_pkg::COEF_FRAC_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_shr;
   logic signed [ACC_W-1:0]  prod_low;

   assign prod_shr = $signed(prod_ff[PROD_W-1:FRAC]);
   assign prod_low = $signed(prod_ff[ACC_W-1:0]);

   always_comb begin
      prod_in = ctrl.mul_en ? op_a * op_b : prod_ff;
      unique case (ctrl.acc_sel)
         adpcm_pkg::ACC_HOLD:     acc_in = acc_ff;
         adpcm_pkg::ACC_LOAD_SHR: acc_in = prod_shr;
         adpcm_pkg::ACC_ADD_SHR:  acc_in = acc_ff + prod_shr;
         adpcm_pkg::ACC_ADD_FULL: acc_in = acc_ff + prod_low;
         default:                 acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/adpcm_4bit_predictor_decoder.sv =====
// ----------------------------------------------------------------------------
// adpcm_4bit_predictor_decoder
// Byte-serial 4-bit ADPCM decoder with two-tap predictor per channel.
// ----------------------------------------------------------------------------
//  channel  ports                                   flow
//  req      req_valid / req_stall, enc_byte, start   one stream byte in
//  rsp      rsp_valid / rsp_stall, pcm, chan, last   0 or 2 samples out
//  csr      csr_write_en, csr_index, csr_write_data  register write, no wait
//
//  A scale byte is handled in the accept step alone. A data byte runs from the
//  accept step through these steps per sample on the one shared multiplier
//  (coef1*prev1, coef2*prev2, code*scale, sum, clamp and store).
//  A sample waits in the store step while the output register is stalled.
//  Reset is synchronous; the input is stalled whenever a byte is in work.
// ----------------------------------------------------------------------------
module adpcm_4bit_predictor_decoder #(
   parameter int MAX_CHANNELS = adpcm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [adpcm_pkg::BYTE_W-1:0]            req_enc_byte,
   input  logic                                    req_stream_start,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [adpcm_pkg::SAMPLE_W-1:0]   rsp_pcm_sample,
   output logic                                    rsp_chan_index,
   output logic                                    rsp_run_last,
   input  logic                                    csr_write_en,
   input  logic [adpcm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [adpcm_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int SW    = adpcm_pkg::SAMPLE_W;
   localparam int BW    = adpcm_pkg::BYTE_W;
   localparam int OW    = adpcm_pkg::OPERAND_W;
   localparam int ACC_W = adpcm_pkg::ACC_W;
   localparam int SCW   = adpcm_pkg::SCALE_W;
   localparam int CCW   = adpcm_pkg::CHAN_CNT_W;
   localparam int NW    = adpcm_pkg::NIBBLE_W;
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(adpcm_pkg::SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(adpcm_pkg::SAMPLE_MIN);
   localparam logic [BW-1:0]  MIN_FRAME    = BW'(adpcm_pkg::MIN_FRAME_SIZE);
   localparam logic [CCW-1:0] STEREO_COUNT = CCW'(adpcm_pkg::STEREO_COUNT);

   // configuration
   logic signed [SW-1:0] coef_one_ff, coef_two_ff;
   logic [CCW-1:0]       chan_count_ff;
   logic [BW-1:0]        frame_size_ff;
   logic signed [SW-1:0] start_one_left_ff, start_two_left_ff;
   logic signed [SW-1:0] start_one_right_ff, start_two_right_ff;

   // framing and history
   logic [BW-1:0]        byte_pos_ff, byte_pos_in;
   logic                 chan_now_ff, chan_now_in;
   logic [BW-1:0]        scale_hi_ff, scale_hi_in;
   logic [SCW-1:0]       step_scale_ff, step_scale_in;
   logic signed [SW-1:0] prev_one_ff [MAX_CHANNELS];
   logic signed [SW-1:0] prev_one_in [MAX_CHANNELS];
   logic signed [SW-1:0] prev_two_ff [MAX_CHANNELS];
   logic signed [SW-1:0] prev_two_in [MAX_CHANNELS];

   // sequencer
   adpcm_pkg::state_type state_ff, state_in;
   logic [BW-1:0]        byte_ff, byte_in;
   logic [CH_W-1:0]      ch_ff, ch_in;
   logic                 nibble_ff, nibble_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;
   logic                 rsp_chan_ff, rsp_chan_in;
   logic                 rsp_last_ff, rsp_last_in;

   // shared unit
   adpcm_pkg::mac_ctrl_type   mac_ctrl;
   logic signed [OW-1:0]      op_a, op_b;
   logic signed [ACC_W-1:0]   mac_acc;

   logic                 req_fire;
   logic                 stereo;
   logic [BW-1:0]        pos_eff;
   logic                 chan_eff;
   logic [BW-1:0]        fsize;
   logic                 frame_end;
   logic                 out_free;
   logic [NW-1:0]        code;
   logic signed [SW-1:0] sample;

   adpcm_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (mac_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_one_ff        <= '0;
         coef_two_ff        <= '0;
         chan_count_ff      <= adpcm_pkg::CHAN_COUNT_RESET;
         frame_size_ff      <= adpcm_pkg::FRAME_SIZE_RESET;
         start_one_left_ff  <= '0;
         start_two_left_ff  <= '0;
         start_one_right_ff <= '0;
         start_two_right_ff <= '0;
      end else if (csr_write_en) begin
         unique case (adpcm_pkg::csr_reg_type'(csr_index))
            adpcm_pkg::CSR_COEF_ONE:       coef_one_ff        <= csr_write_data;
            adpcm_pkg::CSR_COEF_TWO:       coef_two_ff        <= csr_write_data;
            adpcm_pkg::CSR_CHANNEL_COUNT:  chan_count_ff      <= csr_write_data[CCW-1:0];
            adpcm_pkg::CSR_FRAME_SIZE:     frame_size_ff      <= csr_write_data[BW-1:0];
            adpcm_pkg::CSR_PREV_ONE_LEFT:  start_one_left_ff  <= csr_write_data;
            adpcm_pkg::CSR_PREV_TWO_LEFT:  start_two_left_ff  <= csr_write_data;
            adpcm_pkg::CSR_PREV_ONE_RIGHT: start_one_right_ff <= csr_write_data;
            adpcm_pkg::CSR_PREV_TWO_RIGHT: start_two_right_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= adpcm_pkg::ST_IDLE;
         byte_pos_ff   <= '0;
         chan_now_ff   <= 1'b0;
         scale_hi_ff   <= '0;
         step_scale_ff <= adpcm_pkg::STEP_SCALE_RESET;
         nibble_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            prev_one_ff[i] <= '0;
            prev_two_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         byte_pos_ff   <= byte_pos_in;
         chan_now_ff   <= chan_now_in;
         scale_hi_ff   <= scale_hi_in;
         step_scale_ff <= step_scale_in;
         nibble_ff     <= nibble_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            prev_one_ff[i] <= prev_one_in[i];
            prev_two_ff[i] <= prev_two_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      ch_ff         <= ch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      req_fire  = req_valid && (state_ff == adpcm_pkg::ST_IDLE);
      stereo    = (MAX_CHANNELS > 1) && (chan_count_ff >= STEREO_COUNT);
      pos_eff   = req_stream_start ? '0 : byte_pos_ff;
      chan_eff  = (req_stream_start || !stereo) ? 1'b0 : chan_now_ff;
      fsize     = (frame_size_ff < MIN_FRAME) ? MIN_FRAME : frame_size_ff;
      frame_end = ({1'b0, pos_eff} + (BW + 1)'(1)) >= {1'b0, fsize};
      out_free  = !rsp_valid_ff || !rsp_stall;
      code      = nibble_ff ? byte_ff[NW-1:0] : byte_ff[BW-1:NW];

      if (mac_acc > ACC_MAX) begin
         sample = SW'(ACC_MAX);
      end else if (mac_acc < ACC_MIN) begin
         sample = SW'(ACC_MIN);
      end else begin
         sample = mac_acc[SW-1:0];
      end

      state_in      = state_ff;
      byte_pos_in   = byte_pos_ff;
      chan_now_in   = chan_now_ff;
      scale_hi_in   = scale_hi_ff;
      step_scale_in = step_scale_ff;
      byte_in       = byte_ff;
      ch_in         = ch_ff;
      nibble_in     = nibble_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_last_in   = rsp_last_ff;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         prev_one_in[i] = prev_one_ff[i];
         prev_two_in[i] = prev_two_ff[i];
      end

      mac_ctrl.mul_en  = 1'b0;
      mac_ctrl.acc_sel = adpcm_pkg::ACC_HOLD;
      op_a             = '0;
      op_b             = '0;

      unique case (state_ff)
         adpcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_stream_start) begin
                  prev_one_in[0] = start_one_left_ff;
                  prev_two_in[0] = start_two_left_ff;
                  if (MAX_CHANNELS > 1) begin
                     prev_one_in[MAX_CHANNELS-1] = start_one_right_ff;
                     prev_two_in[MAX_CHANNELS-1] = start_two_right_ff;
                  end
               end
               if (pos_eff == '0) begin
                  scale_hi_in = req_enc_byte;
               end else if (pos_eff == BW'(1)) begin
                  step_scale_in = {1'b0, scale_hi_ff, req_enc_byte} + SCW'(1);
               end else begin
                  byte_in   = req_enc_byte;
                  ch_in     = CH_W'(chan_eff);
                  nibble_in = 1'b0;
                  state_in  = adpcm_pkg::ST_MUL_ONE;
               end
               if (frame_end) begin
                  byte_pos_in = '0;
                  chan_now_in = stereo ? ~chan_eff : 1'b0;
               end else begin
                  byte_pos_in = pos_eff + BW'(1);
                  chan_now_in = chan_eff;
               end
            end
         end
         adpcm_pkg::ST_MUL_ONE: begin
            op_a            = {{(OW-SW){coef_one_ff[SW-1]}}, coef_one_ff};
            op_b            = {{(OW-SW){prev_one_ff[ch_ff][SW-1]}}, prev_one_ff[ch_ff]};
            mac_ctrl.mul_en = 1'b1;
            state_in        = adpcm_pkg::ST_MUL_TWO;
         end
         adpcm_pkg::ST_MUL_TWO: begin
            op_a             = {{(OW-SW){coef_two_ff[SW-1]}}, coef_two_ff};
            op_b             = {{(OW-SW){prev_two_ff[ch_ff][SW-1]}}, prev_two_ff[ch_ff]};
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.acc_sel = adpcm_pkg::ACC_LOAD_SHR;
            state_in         = adpcm_pkg::ST_MUL_STEP;
         end
         adpcm_pkg::ST_MUL_STEP: begin
            op_a             = {{(OW-NW){code[NW-1]}}, code};
            op_b             = {{(OW-SCW){1'b0}}, step_scale_ff};
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.acc_sel = adpcm_pkg::ACC_ADD_SHR;
            state_in         = adpcm_pkg::ST_SUM;
         end
         adpcm_pkg::ST_SUM: begin
            mac_ctrl.acc_sel = adpcm_pkg::ACC_ADD_FULL;
            state_in         = adpcm_pkg::ST_STORE;
         end
         adpcm_pkg::ST_STORE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_sample_in      = sample;
               rsp_chan_in        = ch_ff[0];
               rsp_last_in        = nibble_ff;
               prev_two_in[ch_ff] = prev_one_ff[ch_ff];
               prev_one_in[ch_ff] = sample;
               if (nibble_ff) begin
                  state_in = adpcm_pkg::ST_IDLE;
               end else begin
                  nibble_in = 1'b1;
                  state_in  = adpcm_pkg::ST_MUL_ONE;
               end
            end
         end
         default: state_in = adpcm_pkg::ST_IDLE;
      endcase
   end

   assign req_stall      = (state_ff != adpcm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_sample_ff;
   assign rsp_chan_index = rsp_chan_ff;
   assign rsp_run_last   = rsp_last_ff;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit ADPCM decoder. A driver feeds stream
// bytes from a queue, and a monitor decodes every accepted byte in step with
// the block. Each sample that comes out is checked against the oldest
// predicted sample. The bench runs through several register settings: mono
// and stereo, short and long frames, extreme coefficients and histories,
// full scale and clamping, and frame changes in mid-stream.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_PAUSE    = 40;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BYTES    = 200;

   typedef struct packed {
      logic       start;
      logic [7:0] enc;
   } stream_byte_type;

   typedef struct packed {
      logic signed [15:0] pcm;
      logic               chan;
      logic               last;
   } pcm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_enc_byte = '0;
   logic        req_stream_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_pcm_sample;
   logic        rsp_chan_index;
   logic        rsp_run_last;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;

   // register mirror
   logic signed [15:0] coef_one = '0;
   logic signed [15:0] coef_two = '0;
   logic [1:0]         chan_count = adpcm_pkg::CHAN_COUNT_RESET;
   logic [7:0]         frame_len = adpcm_pkg::FRAME_SIZE_RESET;
   logic signed [15:0] reload_one [2] = '{16'sd0, 16'sd0};
   logic signed [15:0] reload_two [2] = '{16'sd0, 16'sd0};

   // decoder state mirror
   logic [7:0]         byte_pos = '0;
   logic               cur_chan = 1'b0;
   logic [7:0]         scale_hi = '0;
   logic [16:0]        step_scale = adpcm_pkg::STEP_SCALE_RESET;
   logic signed [15:0] hist_one [2] = '{16'sd0, 16'sd0};
   logic signed [15:0] hist_two [2] = '{16'sd0, 16'sd0};

   stream_byte_type byte_queue [$];
   pcm_result_type  pcm_expected [$];

   int bytes_sent      = 0;
   int bytes_taken     = 0;
   int samples_checked = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;
   int settings_used   = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;

   adpcm_4bit_predictor_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_enc_byte     (req_enc_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pcm_sample   (rsp_pcm_sample),
      .rsp_chan_index   (rsp_chan_index),
      .rsp_run_last     (rsp_run_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] predict_sample(input logic signed [3:0] code,
         input logic [16:0] scale, input logic signed [15:0] c1, p1, c2, p2);
      int acc;
      acc = int'(code) * int'(scale)
            + ((int'(c1) * int'(p1)) >>> adpcm_pkg::COEF_FRAC_BITS)
            + ((int'(c2) * int'(p2)) >>> adpcm_pkg::COEF_FRAC_BITS);
      if (acc > adpcm_pkg::SAMPLE_MAX) acc = adpcm_pkg::SAMPLE_MAX;
      if (acc < adpcm_pkg::SAMPLE_MIN) acc = adpcm_pkg::SAMPLE_MIN;
      return acc[15:0];
   endfunction

   task automatic decode_nibble(input logic ch, input logic [3:0] code, input logic last);
      logic signed [15:0] s;
      s = predict_sample(code, step_scale, coef_one, hist_one[ch], coef_two, hist_two[ch]);
      hist_two[ch] = hist_one[ch];
      hist_one[ch] = s;
      pcm_expected.push_back('{pcm: s, chan: ch, last: last});
   endtask

   task automatic decode_stream_byte(input logic [7:0] b, input logic st);
      logic [7:0] fsize;
      logic       stereo;
      logic       ch;
      fsize  = (frame_len < adpcm_pkg::MIN_FRAME_SIZE) ?
               8'(adpcm_pkg::MIN_FRAME_SIZE) : frame_len;
      stereo = (chan_count >= adpcm_pkg::STEREO_COUNT);
      if (st) begin
         hist_one = reload_one;
         hist_two = reload_two;
         byte_pos = '0;
         cur_chan = 1'b0;
      end
      if (!stereo) cur_chan = 1'b0;
      ch = cur_chan;
      if (byte_pos == 0) begin
         scale_hi = b;
      end else if (byte_pos == 1) begin
         step_scale = {scale_hi, b} + 17'd1;
      end else begin
         decode_nibble(ch, b[7:4], 1'b0);
         decode_nibble(ch, b[3:0], 1'b1);
      end
      if (int'(byte_pos) + 1 >= int'(fsize)) begin
         byte_pos = '0;
         cur_chan = stereo ? ~cur_chan : 1'b0;
      end else begin
         byte_pos = byte_pos + 8'd1;
      end
   endtask

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(negedge clock) begin : driver
      stream_byte_type item;
      logic            busy;
      busy = req_valid && (bytes_taken != bytes_sent);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!busy) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = byte_queue.pop_front();
            req_enc_byte     <= item.enc;
            req_stream_start <= item.start;
            req_valid        <= 1'b1;
            bytes_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      pcm_result_type want;
      logic           moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            samples_checked++;
            if (pcm_expected.size() == 0) begin
               flag_mismatch($sformatf("unexpected sample %0d chan %0d last %0d",
                  rsp_pcm_sample, rsp_chan_index, rsp_run_last));
            end else begin
               want = pcm_expected.pop_front();
               if (rsp_pcm_sample !== want.pcm)
                  flag_mismatch($sformatf("pcm_sample %0d, want %0d",
                     rsp_pcm_sample, want.pcm));
               if (rsp_chan_index !== want.chan)
                  flag_mismatch($sformatf("chan_index %0d, want %0d",
                     rsp_chan_index, want.chan));
               if (rsp_run_last !== want.last)
                  flag_mismatch($sformatf("run_last %0d, want %0d",
                     rsp_run_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            bytes_taken++;
            decode_stream_byte(req_enc_byte, req_stream_start);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
            $display("adpcm_4bit_predictor_decoder regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input adpcm_pkg::csr_reg_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         adpcm_pkg::CSR_COEF_ONE:       coef_one = value;
         adpcm_pkg::CSR_COEF_TWO:       coef_two = value;
         adpcm_pkg::CSR_CHANNEL_COUNT:  chan_count = value[1:0];
         adpcm_pkg::CSR_FRAME_SIZE:     frame_len = value[7:0];
         adpcm_pkg::CSR_PREV_ONE_LEFT:  reload_one[0] = value;
         adpcm_pkg::CSR_PREV_TWO_LEFT:  reload_two[0] = value;
         adpcm_pkg::CSR_PREV_ONE_RIGHT: reload_one[1] = value;
         adpcm_pkg::CSR_PREV_TWO_RIGHT: reload_two[1] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic push_byte(input logic st, input logic [7:0] b);
      byte_queue.push_back('{start: st, enc: b});
   endtask

   task automatic wait_for_drain();
      while (byte_queue.size() != 0 || bytes_sent != bytes_taken
             || pcm_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h1000;
         default: return 16'($urandom_range(0, 16383) - 8192);
      endcase
   endfunction

   task automatic random_settings();
      logic [15:0] fsize;
      case ($urandom_range(9))
         0: fsize = 16'($urandom_range(0, 2));
         1: fsize = 16'd255;
         default: fsize = 16'($urandom_range(3, 24));
      endcase
      write_reg(adpcm_pkg::CSR_COEF_ONE, pick_coef());
      write_reg(adpcm_pkg::CSR_COEF_TWO, pick_coef());
      write_reg(adpcm_pkg::CSR_CHANNEL_COUNT, 16'($urandom_range(0, 3)));
      write_reg(adpcm_pkg::CSR_FRAME_SIZE, fsize);
      write_reg(adpcm_pkg::CSR_PREV_ONE_LEFT, pick_word());
      write_reg(adpcm_pkg::CSR_PREV_TWO_LEFT, pick_word());
      write_reg(adpcm_pkg::CSR_PREV_ONE_RIGHT, pick_word());
      write_reg(adpcm_pkg::CSR_PREV_TWO_RIGHT, pick_word());
      settings_used++;
   endtask

   // well-formed frames with random content and the odd restart in mid-stream
   task automatic queue_stream(input int count, input bit open_with_start);
      int          pos;
      int          fsize;
      logic        st;
      logic [7:0]  b;
      logic [15:0] scale_word;
      fsize      = (frame_len < adpcm_pkg::MIN_FRAME_SIZE) ?
                   adpcm_pkg::MIN_FRAME_SIZE : int'(frame_len);
      pos        = int'(byte_pos);
      scale_word = 16'($urandom);
      for (int k = 0; k < count; k++) begin
         st = (k == 0 && open_with_start) || ($urandom_range(99) < 2);
         if (st) pos = 0;
         if (pos == 0) begin
            case ($urandom_range(3))
               0: scale_word = 16'($urandom_range(0, 255));
               1: scale_word = 16'($urandom_range(0, 4095));
               2: scale_word = 16'hFFFF;
               default: scale_word = 16'($urandom);
            endcase
            b = scale_word[15:8];
         end else if (pos == 1) begin
            b = scale_word[7:0];
         end else begin
            b = 8'($urandom);
         end
         push_byte(st, b);
         pos = (pos + 1 >= fsize) ? 0 : pos + 1;
      end
   endtask

   initial begin
      send_idle_pct = 9;
      recv_idle_pct = 45;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stereo, frame below minimum, full scale, clamping, restart
      write_reg(adpcm_pkg::CSR_COEF_ONE, 16'h7FFF);
      write_reg(adpcm_pkg::CSR_COEF_TWO, 16'h8000);
      write_reg(adpcm_pkg::CSR_CHANNEL_COUNT, 16'd2);
      write_reg(adpcm_pkg::CSR_FRAME_SIZE, 16'd0);
      write_reg(adpcm_pkg::CSR_PREV_ONE_LEFT, 16'h7FFF);
      write_reg(adpcm_pkg::CSR_PREV_TWO_LEFT, 16'h8000);
      write_reg(adpcm_pkg::CSR_PREV_ONE_RIGHT, 16'h8000);
      write_reg(adpcm_pkg::CSR_PREV_TWO_RIGHT, 16'h7FFF);
      settings_used++;
      push_byte(1'b1, 8'hFF); push_byte(1'b0, 8'hFF); push_byte(1'b0, 8'h78);
      push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h80);
      push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h10); push_byte(1'b0, 8'hF7);
      push_byte(1'b1, 8'h00); push_byte(1'b0, 8'h05); push_byte(1'b0, 8'h0F);
      wait_for_drain();

      // mono from a zero count, longest frame, stopped mid-frame
      write_reg(adpcm_pkg::CSR_COEF_ONE, 16'h1000);
      write_reg(adpcm_pkg::CSR_COEF_TWO, 16'hF000);
      write_reg(adpcm_pkg::CSR_CHANNEL_COUNT, 16'd0);
      write_reg(adpcm_pkg::CSR_FRAME_SIZE, 16'd255);
      settings_used++;
      push_byte(1'b1, 8'h00); push_byte(1'b0, 8'h03);
      repeat (5) push_byte(1'b0, 8'($urandom));
      wait_for_drain();

      // shrink the frame under the current position without a restart
      write_reg(adpcm_pkg::CSR_CHANNEL_COUNT, 16'd3);
      write_reg(adpcm_pkg::CSR_FRAME_SIZE, 16'd1);
      settings_used++;
      push_byte(1'b0, 8'hA5); push_byte(1'b0, 8'h00);
      push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h5A);
      wait_for_drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 45;
         end else if (ph < 6) begin
            send_idle_pct = 45;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_settings();
         queue_stream(PHASE_BYTES, (ph % 3) != 2);
         wait_for_drain();
      end

      $display("covered %0d stream bytes and %0d samples over %0d register settings",
         bytes_taken, samples_checked, settings_used);
      $display("mono and stereo, short and long frames, full scale, restarts; %0d mismatches",
         mismatches);
      if (mismatches == 0 && pcm_expected.size() == 0) begin
         $display("adpcm_4bit_predictor_decoder regression: pass");
      end else begin
         $display("adpcm_4bit_predictor_decoder regression: fail");
      end
      $finish;
   end

endmodule
